### hw/rtl/tkdlp_pkg.sv
package tkdlp_pkg;

    localparam int TIME_W    = 32;
    localparam int CFG_W     = 16;
    localparam int KEY_COUNT = 3;
    localparam int KEY_IDX_W = $clog2(KEY_COUNT);

    typedef logic [KEY_IDX_W-1:0] key_idx_t;
    typedef logic [TIME_W-1:0]    time_t;
    typedef logic [CFG_W-1:0]     cfg_t;

    localparam key_idx_t KEY_UP   = key_idx_t'(0);
    localparam key_idx_t KEY_DOWN = key_idx_t'(1);
    localparam key_idx_t KEY_OK   = key_idx_t'(2);

    typedef enum logic [0:0] {
        REG_DEBOUNCE   = 1'b0,
        REG_LONG_PRESS = 1'b1
    } cfg_index_t;

    localparam cfg_t DEBOUNCE_RESET   = cfg_t'(30);
    localparam cfg_t LONG_PRESS_RESET = cfg_t'(800);

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_UP_SHORT   = 3'd1,
        EV_DOWN_SHORT = 3'd2,
        EV_OK_SHORT   = 3'd3,
        EV_OK_LONG    = 3'd4
    } key_event_t;

    function automatic key_event_t short_event(input key_idx_t idx);
        key_event_t ev;
        unique case (idx)
            KEY_UP:   ev = EV_UP_SHORT;
            KEY_DOWN: ev = EV_DOWN_SHORT;
            KEY_OK:   ev = EV_OK_SHORT;
            default:  ev = EV_NONE;
        endcase
        return ev;
    endfunction

endpackage

### hw/rtl/three_key_debounce_long_press_unit.sv
// Debounces three active-low keys (up, down, ok) from timestamped scan beats and reports one
// key_event per scan: short events on release (none for ok after its long event), one long
// event for ok held past long_press_ms. Takes one scan beat per clock while in_stall is low; a
// scan passes an input register and then the result register, which out_stall can hold. All key
// state updates together with the result register. Timestamps wrap modulo 2^32. Write the
// debounce_ms and long_press_ms registers only while no scans are in flight.
module three_key_debounce_long_press_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  tkdlp_pkg::time_t        now_ms,
    input  logic                    up_level,
    input  logic                    down_level,
    input  logic                    ok_level,
    output logic                    out_valid,
    input  logic                    out_stall,
    output tkdlp_pkg::key_event_t   key_event,
    input  logic                    cfg_we,
    input  tkdlp_pkg::cfg_index_t   cfg_index,
    input  tkdlp_pkg::cfg_t         cfg_data
);
    import tkdlp_pkg::*;

    cfg_t       debounce_reg;
    cfg_t       long_press_reg;

    logic       in_valid_reg;
    time_t      now_reg;
    logic [KEY_COUNT-1:0] level_reg;

    logic       out_valid_reg;
    key_event_t key_event_reg;
    key_event_t key_event_next;

    logic [KEY_COUNT-1:0] prev_reg,    prev_next;
    logic [KEY_COUNT-1:0] settled_reg, settled_next;
    time_t      change_time_reg [KEY_COUNT];
    time_t      change_time_next [KEY_COUNT];
    time_t      press_time_reg,  press_time_next;
    logic       long_done_reg,   long_done_next;

    logic       advance;
    logic       process;

    assign advance   = !out_valid_reg || !out_stall;
    assign process   = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign key_event = key_event_reg;

    always_comb
    begin
        logic  stop;
        logic  raw;
        time_t el;
        prev_next        = prev_reg;
        settled_next     = settled_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        long_done_next   = long_done_reg;
        key_event_next   = EV_NONE;
        stop             = 1'b0;
        el               = '0;
        for (int k = 0; k < KEY_COUNT; k++)
        begin
            raw = level_reg[k];
            if (!stop)
            begin
                if (raw != prev_reg[k])
                begin
                    prev_next[k]        = raw;
                    change_time_next[k] = now_reg;
                end
                el = now_reg - change_time_next[k];
                if (el >= time_t'(debounce_reg))
                begin
                    if (raw != settled_reg[k])
                    begin
                        settled_next[k] = raw;
                        if (!raw)
                        begin
                            if (key_idx_t'(k) == KEY_OK)
                            begin
                                press_time_next = now_reg;
                                long_done_next  = 1'b0;
                            end
                        end
                        else if (key_idx_t'(k) != KEY_OK || !long_done_next)
                        begin
                            key_event_next = short_event(key_idx_t'(k));
                            stop           = 1'b1;
                        end
                    end
                    // long press on ok, once per press
                    if (!stop && key_idx_t'(k) == KEY_OK && !settled_next[k] &&
                        !long_done_next &&
                        (now_reg - press_time_next) >= time_t'(long_press_reg))
                    begin
                        long_done_next = 1'b1;
                        key_event_next = EV_OK_LONG;
                        stop           = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= DEBOUNCE_RESET;
            long_press_reg <= LONG_PRESS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DEBOUNCE:   debounce_reg   <= cfg_data;
                REG_LONG_PRESS: long_press_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            now_reg   <= now_ms;
            level_reg <= {ok_level, down_level, up_level};
        end
        if (process)
            key_event_reg <= key_event_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '1;
            settled_reg    <= '1;
            press_time_reg <= '0;
            long_done_reg  <= 1'b0;
            for (int k = 0; k < KEY_COUNT; k++)
                change_time_reg[k] <= '0;
        end
        else if (process)
        begin
            prev_reg        <= prev_next;
            settled_reg     <= settled_next;
            press_time_reg  <= press_time_next;
            long_done_reg   <= long_done_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule
